/* src/icsp_pcs_pkg.sv */
// Shared types and constants for the ICSP programming command sequencer.
`default_nettype none
package icsp_pcs_pkg;

	localparam int ROW_WORDS   = 8;
	localparam int IDX_W       = 3;   // word index within a record
	localparam int NWORDS_W    = 4;   // word count 0..8

	typedef logic [15:0] word_t;
	typedef logic [4:0]  count_t;
	typedef logic [1:0]  reg_addr_t;

	localparam word_t     CONFIG_BASE = 16'h2000;
	localparam word_t     CONFIG_FILL = 16'h3FFF;
	localparam logic [IDX_W-1:0] ROW_LAST_IDX = 3'd7;

	localparam reg_addr_t REG_ERASE_WAIT = 2'd0;
	localparam reg_addr_t REG_ROW_WAIT   = 2'd1;
	localparam reg_addr_t REG_WORD_WAIT  = 2'd2;

	localparam word_t ERASE_WAIT_RST = 16'd8000;
	localparam word_t ROW_WAIT_RST   = 16'd8000;
	localparam word_t WORD_WAIT_RST  = 16'd1000;

	typedef enum logic [4:0] {
		OP_LOAD_CONFIG  = 5'h00,
		OP_LOAD_PROGRAM = 5'h02,
		OP_INCR         = 5'h06,
		OP_PROG_ERASE   = 5'h08,
		OP_END_PROG     = 5'h17,
		OP_PROG_ONLY    = 5'h18,
		OP_CHIP_ERASE   = 5'h1F
	} op_t;

	typedef enum logic [0:0] {
		REQ_START  = 1'b0,
		REQ_RECORD = 1'b1
	} req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PLAN,
		ST_ERASE,
		ST_CFG,
		ST_GAP,
		ST_ROW_LOAD,
		ST_ROW_INCR,
		ST_ROW_PE,
		ST_ROW_END,
		ST_ROW_NEXT,
		ST_W_LOAD,
		ST_W_PROG,
		ST_W_END,
		ST_W_INCR
	} state_t;

	typedef enum logic [1:0] {
		PAY_NONE,
		PAY_FILL,
		PAY_WORD
	} pay_sel_t;

	typedef enum logic [0:0] {
		REP_ONE,
		REP_GAP
	} rep_sel_t;

	typedef enum logic [1:0] {
		WAIT_NONE,
		WAIT_ERASE,
		WAIT_ROW,
		WAIT_WORD
	} wait_sel_t;

	typedef enum logic [2:0] {
		ADDR_KEEP,
		ADDR_CLEAR,
		ADDR_CFG,
		ADDR_GAP,
		ADDR_INC
	} addr_op_t;

	// controller -> datapath
	typedef struct packed {
		logic             load;
		logic             emit;
		op_t              op;
		logic             has_data;
		pay_sel_t         pay_sel;
		rep_sel_t         rep_sel;
		wait_sel_t        wait_sel;
		addr_op_t         addr_op;
		logic             last;
		logic [IDX_W-1:0] idx;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic                out_free;
		logic                is_start;
		logic                empty;
		logic                need_cfg;
		logic                need_gap;
		logic                row_path;
		logic [NWORDS_W-1:0] nwords;
		logic                in_cfg;
	} ctl_sts_t;

endpackage
`default_nettype wire

/* src/icsp_pcs_rec_if.sv */
// Record/start item channel.
`default_nettype none
interface icsp_pcs_rec_if;
	logic                 valid;
	logic                 ready;
	logic                 req_type;
	icsp_pcs_pkg::word_t  byte_offset;
	icsp_pcs_pkg::count_t byte_count;
	icsp_pcs_pkg::word_t  word0;
	icsp_pcs_pkg::word_t  word1;
	icsp_pcs_pkg::word_t  word2;
	icsp_pcs_pkg::word_t  word3;
	icsp_pcs_pkg::word_t  word4;
	icsp_pcs_pkg::word_t  word5;
	icsp_pcs_pkg::word_t  word6;
	icsp_pcs_pkg::word_t  word7;

	modport source (output valid, req_type, byte_offset, byte_count,
		word0, word1, word2, word3, word4, word5, word6, word7, input ready);
	modport sink (input valid, req_type, byte_offset, byte_count,
		word0, word1, word2, word3, word4, word5, word6, word7, output ready);
endinterface
`default_nettype wire

/* src/icsp_pcs_cmd_if.sv */
// Programming command channel.
`default_nettype none
interface icsp_pcs_cmd_if;
	logic                valid;
	logic                ready;
	logic [4:0]          command;
	logic                has_data;
	icsp_pcs_pkg::word_t payload;
	icsp_pcs_pkg::word_t repeat_res;
	icsp_pcs_pkg::word_t wait_after_us;
	logic                last;

	modport source (output valid, command, has_data, payload, repeat_res,
		wait_after_us, last, input ready);
	modport sink (input valid, command, has_data, payload, repeat_res,
		wait_after_us, last, output ready);
endinterface
`default_nettype wire

/* src/icsp_pcs_cfg_if.sv */
// Configuration register write channel.
`default_nettype none
interface icsp_pcs_cfg_if;
	logic                    valid;
	logic                    ready;
	icsp_pcs_pkg::reg_addr_t addr;
	icsp_pcs_pkg::word_t     data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

/* src/icsp_pcs_ctrl.sv */
// Sequencer state machine: walks the command list of one item.
`default_nettype none
module icsp_pcs_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   rec_valid,
	output logic                        rec_ready,
	input  wire icsp_pcs_pkg::ctl_sts_t sts,
	output icsp_pcs_pkg::ctl_cmd_t      cmd
);

	icsp_pcs_pkg::state_t state_q, state_d;
	logic [icsp_pcs_pkg::IDX_W-1:0] idx_q, idx_d;
	icsp_pcs_pkg::state_t body_st;
	logic body_none;
	logic w_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= icsp_pcs_pkg::ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		body_none = !sts.row_path && (sts.nwords == '0);
		if (sts.row_path)
			body_st = icsp_pcs_pkg::ST_ROW_LOAD;
		else if (sts.nwords != '0)
			body_st = icsp_pcs_pkg::ST_W_LOAD;
		else
			body_st = icsp_pcs_pkg::ST_IDLE;
		w_last = ({1'b0, idx_q} + 4'd1) == sts.nwords;

		state_d      = state_q;
		idx_d        = idx_q;
		rec_ready    = 1'b0;
		cmd          = '0;
		cmd.op       = icsp_pcs_pkg::OP_INCR;
		cmd.pay_sel  = icsp_pcs_pkg::PAY_NONE;
		cmd.rep_sel  = icsp_pcs_pkg::REP_ONE;
		cmd.wait_sel = icsp_pcs_pkg::WAIT_NONE;
		cmd.addr_op  = icsp_pcs_pkg::ADDR_KEEP;
		cmd.idx      = idx_q;

		case (state_q)
			icsp_pcs_pkg::ST_IDLE: begin
				rec_ready = 1'b1;
				cmd.load  = rec_valid;
				if (rec_valid)
					state_d = icsp_pcs_pkg::ST_PLAN;
			end
			icsp_pcs_pkg::ST_PLAN: begin
				idx_d = '0;
				if (sts.is_start)
					state_d = icsp_pcs_pkg::ST_ERASE;
				else if (sts.empty)
					state_d = icsp_pcs_pkg::ST_IDLE;
				else if (sts.need_cfg)
					state_d = icsp_pcs_pkg::ST_CFG;
				else if (sts.need_gap)
					state_d = icsp_pcs_pkg::ST_GAP;
				else
					state_d = body_st;
			end
			icsp_pcs_pkg::ST_ERASE: begin
				cmd.emit     = sts.out_free;
				cmd.op       = icsp_pcs_pkg::OP_CHIP_ERASE;
				cmd.wait_sel = icsp_pcs_pkg::WAIT_ERASE;
				cmd.addr_op  = icsp_pcs_pkg::ADDR_CLEAR;
				cmd.last     = 1'b1;
				if (sts.out_free)
					state_d = icsp_pcs_pkg::ST_IDLE;
			end
			icsp_pcs_pkg::ST_CFG: begin
				cmd.emit     = sts.out_free;
				cmd.op       = icsp_pcs_pkg::OP_LOAD_CONFIG;
				cmd.has_data = 1'b1;
				cmd.pay_sel  = icsp_pcs_pkg::PAY_FILL;
				cmd.addr_op  = icsp_pcs_pkg::ADDR_CFG;
				cmd.last     = !sts.need_gap && body_none;
				if (sts.out_free)
					state_d = sts.need_gap ? icsp_pcs_pkg::ST_GAP : body_st;
			end
			icsp_pcs_pkg::ST_GAP: begin
				cmd.emit    = sts.out_free;
				cmd.op      = icsp_pcs_pkg::OP_INCR;
				cmd.rep_sel = icsp_pcs_pkg::REP_GAP;
				cmd.addr_op = icsp_pcs_pkg::ADDR_GAP;
				cmd.last    = body_none;
				if (sts.out_free)
					state_d = body_st;
			end
			icsp_pcs_pkg::ST_ROW_LOAD: begin
				cmd.emit     = sts.out_free;
				cmd.op       = icsp_pcs_pkg::OP_LOAD_PROGRAM;
				cmd.has_data = 1'b1;
				cmd.pay_sel  = icsp_pcs_pkg::PAY_WORD;
				cmd.addr_op  = icsp_pcs_pkg::ADDR_INC;
				if (sts.out_free)
					state_d = (idx_q == icsp_pcs_pkg::ROW_LAST_IDX) ?
						icsp_pcs_pkg::ST_ROW_PE : icsp_pcs_pkg::ST_ROW_INCR;
			end
			icsp_pcs_pkg::ST_ROW_INCR: begin
				cmd.emit = sts.out_free;
				cmd.op   = icsp_pcs_pkg::OP_INCR;
				if (sts.out_free) begin
					idx_d   = idx_q + 3'd1;
					state_d = icsp_pcs_pkg::ST_ROW_LOAD;
				end
			end
			icsp_pcs_pkg::ST_ROW_PE: begin
				cmd.emit     = sts.out_free;
				cmd.op       = icsp_pcs_pkg::OP_PROG_ERASE;
				cmd.wait_sel = icsp_pcs_pkg::WAIT_ROW;
				if (sts.out_free)
					state_d = icsp_pcs_pkg::ST_ROW_END;
			end
			icsp_pcs_pkg::ST_ROW_END: begin
				cmd.emit = sts.out_free;
				cmd.op   = icsp_pcs_pkg::OP_END_PROG;
				if (sts.out_free)
					state_d = icsp_pcs_pkg::ST_ROW_NEXT;
			end
			icsp_pcs_pkg::ST_ROW_NEXT: begin
				cmd.emit = sts.out_free;
				cmd.op   = icsp_pcs_pkg::OP_INCR;
				cmd.last = 1'b1;
				if (sts.out_free)
					state_d = icsp_pcs_pkg::ST_IDLE;
			end
			icsp_pcs_pkg::ST_W_LOAD: begin
				cmd.emit     = sts.out_free;
				cmd.op       = icsp_pcs_pkg::OP_LOAD_PROGRAM;
				cmd.has_data = 1'b1;
				cmd.pay_sel  = icsp_pcs_pkg::PAY_WORD;
				if (sts.out_free)
					state_d = icsp_pcs_pkg::ST_W_PROG;
			end
			icsp_pcs_pkg::ST_W_PROG: begin
				cmd.emit     = sts.out_free;
				cmd.op       = sts.in_cfg ? icsp_pcs_pkg::OP_PROG_ERASE :
					icsp_pcs_pkg::OP_PROG_ONLY;
				cmd.wait_sel = icsp_pcs_pkg::WAIT_WORD;
				if (sts.out_free)
					state_d = icsp_pcs_pkg::ST_W_END;
			end
			icsp_pcs_pkg::ST_W_END: begin
				cmd.emit = sts.out_free;
				cmd.op   = icsp_pcs_pkg::OP_END_PROG;
				if (sts.out_free)
					state_d = icsp_pcs_pkg::ST_W_INCR;
			end
			icsp_pcs_pkg::ST_W_INCR: begin
				cmd.emit    = sts.out_free;
				cmd.op      = icsp_pcs_pkg::OP_INCR;
				cmd.addr_op = icsp_pcs_pkg::ADDR_INC;
				cmd.last    = w_last;
				if (sts.out_free) begin
					if (w_last) begin
						state_d = icsp_pcs_pkg::ST_IDLE;
					end else begin
						idx_d   = idx_q + 3'd1;
						state_d = icsp_pcs_pkg::ST_W_LOAD;
					end
				end
			end
			default: begin
				state_d = icsp_pcs_pkg::ST_IDLE;
			end
		endcase
	end

	a_accept_plans: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_valid && rec_ready) |=> (state_q == icsp_pcs_pkg::ST_PLAN))
		else $error("accepted item did not move to planning");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.last) |=> (state_q == icsp_pcs_pkg::ST_IDLE))
		else $error("sequencer kept running after final command");

	a_row_plan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == icsp_pcs_pkg::ST_ROW_LOAD) |-> sts.row_path)
		else $error("row load without row plan");

endmodule
`default_nettype wire

/* src/icsp_pcs_dp.sv */
// Datapath: record store, address tracking, wait registers, output register.
`default_nettype none
module icsp_pcs_dp #(
	parameter int RECORD_WORDS = 8
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire icsp_pcs_pkg::ctl_cmd_t  cmd,
	output icsp_pcs_pkg::ctl_sts_t       sts,
	// item payload
	input  wire logic                    req_type,
	input  wire icsp_pcs_pkg::word_t     byte_offset,
	input  wire icsp_pcs_pkg::count_t    byte_count,
	input  wire icsp_pcs_pkg::word_t     in_words [icsp_pcs_pkg::ROW_WORDS],
	// register writes
	input  wire logic                    cfg_we,
	input  wire icsp_pcs_pkg::reg_addr_t cfg_addr,
	input  wire icsp_pcs_pkg::word_t     cfg_data,
	// result register
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [4:0]                   out_command,
	output logic                         out_has_data,
	output icsp_pcs_pkg::word_t          out_payload,
	output icsp_pcs_pkg::word_t          out_repeat,
	output icsp_pcs_pkg::word_t          out_wait,
	output logic                         out_last
);

	localparam int IDX_W = (RECORD_WORDS > 1) ? $clog2(RECORD_WORDS) : 1;

	icsp_pcs_pkg::word_t erase_wait_q, row_wait_q, word_wait_q;
	icsp_pcs_pkg::word_t word_addr_q;
	logic                in_cfg_q;

	icsp_pcs_pkg::word_t rec_words_q [RECORD_WORDS];
	logic [14:0]         offset_q;
	logic                is_start_q, empty_q, need_cfg_q, need_gap_q, row_path_q;
	logic [icsp_pcs_pkg::NWORDS_W-1:0] nwords_q;

	logic                out_valid_q;
	logic [4:0]          command_q;
	logic                has_data_q, last_q;
	icsp_pcs_pkg::word_t payload_q, repeat_q, wait_q;

	// decode of the incoming item against current state
	logic [14:0]         offset_w;
	logic [icsp_pcs_pkg::NWORDS_W-1:0] half_cnt, nwords_w;
	logic                need_cfg_w;
	icsp_pcs_pkg::word_t base_addr;

	icsp_pcs_pkg::word_t pay_d, rep_d, wait_d;

	always_comb begin
		offset_w   = byte_offset[15:1];
		half_cnt   = byte_count[4:1];
		nwords_w   = (half_cnt > 4'(RECORD_WORDS)) ? 4'(RECORD_WORDS) : half_cnt;
		need_cfg_w = (offset_w >= icsp_pcs_pkg::CONFIG_BASE[14:0]) && !in_cfg_q;
		base_addr  = need_cfg_w ? icsp_pcs_pkg::CONFIG_BASE : word_addr_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			offset_q   <= offset_w;
			is_start_q <= (req_type == icsp_pcs_pkg::REQ_START);
			empty_q    <= (byte_count == '0);
			need_cfg_q <= need_cfg_w;
			need_gap_q <= {1'b0, offset_w} > base_addr;
			row_path_q <= (offset_w[2:0] == 3'd0) && (nwords_w == 4'(icsp_pcs_pkg::ROW_WORDS));
			nwords_q   <= nwords_w;
			for (int i = 0; i < RECORD_WORDS; i++)
				rec_words_q[i] <= in_words[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			erase_wait_q <= icsp_pcs_pkg::ERASE_WAIT_RST;
			row_wait_q   <= icsp_pcs_pkg::ROW_WAIT_RST;
			word_wait_q  <= icsp_pcs_pkg::WORD_WAIT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				icsp_pcs_pkg::REG_ERASE_WAIT: erase_wait_q <= cfg_data;
				icsp_pcs_pkg::REG_ROW_WAIT:   row_wait_q   <= cfg_data;
				icsp_pcs_pkg::REG_WORD_WAIT:  word_wait_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_addr_q <= '0;
			in_cfg_q    <= 1'b0;
		end else if (cmd.emit) begin
			case (cmd.addr_op)
				icsp_pcs_pkg::ADDR_CLEAR: begin
					word_addr_q <= '0;
					in_cfg_q    <= 1'b0;
				end
				icsp_pcs_pkg::ADDR_CFG: begin
					word_addr_q <= icsp_pcs_pkg::CONFIG_BASE;
					in_cfg_q    <= 1'b1;
				end
				icsp_pcs_pkg::ADDR_GAP: word_addr_q <= {1'b0, offset_q};
				icsp_pcs_pkg::ADDR_INC: word_addr_q <= word_addr_q + 16'd1;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cmd.pay_sel)
			icsp_pcs_pkg::PAY_FILL: pay_d = icsp_pcs_pkg::CONFIG_FILL;
			icsp_pcs_pkg::PAY_WORD: pay_d = rec_words_q[cmd.idx[IDX_W-1:0]];
			default:                pay_d = '0;
		endcase
		case (cmd.rep_sel)
			icsp_pcs_pkg::REP_GAP: rep_d = {1'b0, offset_q} - word_addr_q;
			default:               rep_d = 16'd1;
		endcase
		case (cmd.wait_sel)
			icsp_pcs_pkg::WAIT_ERASE: wait_d = erase_wait_q;
			icsp_pcs_pkg::WAIT_ROW:   wait_d = row_wait_q;
			icsp_pcs_pkg::WAIT_WORD:  wait_d = word_wait_q;
			default:                  wait_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			command_q  <= cmd.op;
			has_data_q <= cmd.has_data;
			payload_q  <= pay_d;
			repeat_q   <= rep_d;
			wait_q     <= wait_d;
			last_q     <= cmd.last;
		end
	end

	always_comb begin
		sts.out_free = !out_valid_q || out_ready;
		sts.is_start = is_start_q;
		sts.empty    = empty_q;
		sts.need_cfg = need_cfg_q;
		sts.need_gap = need_gap_q;
		sts.row_path = row_path_q;
		sts.nwords   = nwords_q;
		sts.in_cfg   = in_cfg_q;
	end

	assign out_valid    = out_valid_q;
	assign out_command  = command_q;
	assign out_has_data = has_data_q;
	assign out_payload  = payload_q;
	assign out_repeat   = repeat_q;
	assign out_wait     = wait_q;
	assign out_last     = last_q;

	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.emit))
		else $error("result register filled without emit");

	a_cfg_jump: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.addr_op == icsp_pcs_pkg::ADDR_CFG) |=>
		(in_cfg_q && word_addr_q == icsp_pcs_pkg::CONFIG_BASE))
		else $error("config jump did not set address and flag");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !cmd.emit)
		else $error("result overwritten while stalled");

endmodule
`default_nettype wire

/* src/icsp_program_command_sequencer_unit.sv */
// Top level of the ICSP programming command sequencer.
//
//  channel | dir | handshake     | carries
//  --------+-----+---------------+------------------------------------------
//  rec     | in  | valid/ready   | start or data record item (up to 8 words)
//  cmd     | out | valid/ready   | one programming command item
//  cfg     | in  | valid/ready   | register write: addr (0..2), 16-bit data
//
//  Steps: the item is taken in idle and planned, then one command item is sent
//  per cycle while cmd is not stalled; no new item is taken before its last command.
//  The sequencer state machine walking the command list sets the rate.
//  Reset: erase/row waits 8000, word wait 1000, address and config flag clear.
//  A stalled cmd channel holds the result register and freezes the sequencer;
//  cfg writes are always taken.
`default_nettype none
module icsp_program_command_sequencer_unit #(
	parameter int RECORD_WORDS = 8
) (
	input wire logic  clk,
	input wire logic  arst_n,
	icsp_pcs_rec_if.sink   rec,
	icsp_pcs_cmd_if.source cmd,
	icsp_pcs_cfg_if.sink   cfg
);

	icsp_pcs_pkg::ctl_cmd_t ctl_cmd;
	icsp_pcs_pkg::ctl_sts_t ctl_sts;
	icsp_pcs_pkg::word_t    rec_words [icsp_pcs_pkg::ROW_WORDS];
	logic                   rec_ready;

	// record words in record order
	assign rec_words[0] = rec.word0;
	assign rec_words[1] = rec.word1;
	assign rec_words[2] = rec.word2;
	assign rec_words[3] = rec.word3;
	assign rec_words[4] = rec.word4;
	assign rec_words[5] = rec.word5;
	assign rec_words[6] = rec.word6;
	assign rec_words[7] = rec.word7;

	assign rec.ready = rec_ready;
	assign cfg.ready = 1'b1;

	icsp_pcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec.valid),
		.rec_ready (rec_ready),
		.sts       (ctl_sts),
		.cmd       (ctl_cmd)
	);

	icsp_pcs_dp #(
		.RECORD_WORDS (RECORD_WORDS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (ctl_cmd),
		.sts          (ctl_sts),
		.req_type     (rec.req_type),
		.byte_offset  (rec.byte_offset),
		.byte_count   (rec.byte_count),
		.in_words     (rec_words),
		.cfg_we       (cfg.valid),
		.cfg_addr     (cfg.addr),
		.cfg_data     (cfg.data),
		.out_valid    (cmd.valid),
		.out_ready    (cmd.ready),
		.out_command  (cmd.command),
		.out_has_data (cmd.has_data),
		.out_payload  (cmd.payload),
		.out_repeat   (cmd.repeat_res),
		.out_wait     (cmd.wait_after_us),
		.out_last     (cmd.last)
	);

endmodule
`default_nettype wire
